>>> rtl/core/iirbq_pkg.sv
// Shared types, register map and default constants for the biquad filter core.
`default_nettype none

package iirbq_pkg;

    localparam int COEF_WIDTH  = 18;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_WIDTH  = 5;
    localparam int NUM_REGS    = 5;

    localparam int FILTER_ORDER_DEF   = 2;
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 15;

    // b0 resets to 1.0 in Q2.15
    localparam logic signed [COEF_WIDTH-1:0] COEF_B0_RESET = 18'sd32768;

    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
    } coef_set_t;

endpackage

`default_nettype wire

>>> rtl/core/iir_biquad_direct_form_one_core.sv
// Top level of the direct form 1 biquad: stream handshake, history and result registers.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one signed sample per beat in
//   the low SAMPLE_WIDTH bits of s_tdata. Output stream (m_tvalid/m_tready/m_tdata/
//   m_tuser) returns one filtered sample per input beat, in order; m_tuser flags
//   that the result was saturated.
//   y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, rounded half up and clamped.
//   Coefficients are Q2.15 (COEF_FRAC_BITS fraction bits), written over the APB
//   port at byte addresses 0x00 b0, 0x04 b1, 0x08 b2, 0x0C a1, 0x10 a2; change
//   them only while the stream is idle.
//   A beat accepted into the input register moves to the output register
//   when that is free or draining, then shows on m_tdata. Throughput: one beat
//   per cycle while m_tready stays high, set by the feedback loop: the five
//   multipliers, the adder tree and the rounding/saturation all sit between the
//   input and output registers, so each output is history for the next sample.
//   Stall: when m_tready is low the result holds in the output register and one
//   more sample is held in the input register; s_tready drops only when both
//   are full.
//   Reset: b0 returns to 1.0, other coefficients to zero, the history clears and
//   both streams come up empty.
`default_nettype none

module iir_biquad_direct_form_one_core
#(
    parameter int FILTER_ORDER   = iirbq_pkg::FILTER_ORDER_DEF,
    parameter int SAMPLE_WIDTH   = iirbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = iirbq_pkg::COEF_FRAC_BITS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input stream; s_tdata bits up from 0: sample_in
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
    // output stream; m_tdata bits up from 0: sample_out
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
    // m_tuser bit 0: clipped
    output logic                                     m_tuser,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [iirbq_pkg::ADDR_WIDTH-1:0]    paddr,
    input  wire logic [iirbq_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic      [iirbq_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                                     pready
);
    import iirbq_pkg::*;

    localparam int TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;
    // taps past the second have no coefficient, so they never reach the output
    localparam int HIST_DEPTH = (FILTER_ORDER > 2) ? 2 : FILTER_ORDER;

    coef_set_t coef;

    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic                           clip_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_hist_reg [HIST_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] y_hist_reg [HIST_DEPTH];

    logic signed [SAMPLE_WIDTH-1:0] y_calc;
    logic                           clip_calc;
    logic                           in_beat;
    logic                           advance;

    iirbq_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    iirbq_mac
    #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .HIST_DEPTH     (HIST_DEPTH)
    )
    u_mac
    (
        .x      (x_reg),
        .x_hist (x_hist_reg),
        .y_hist (y_hist_reg),
        .coef   (coef),
        .y      (y_calc),
        .clip   (clip_calc)
    );

    // advance the held sample whenever the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_beat  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_beat)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                x_hist_reg[k] <= '0;
                y_hist_reg[k] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                for (int k = HIST_DEPTH - 1; k > 0; k--)
                begin
                    x_hist_reg[k] <= x_hist_reg[k-1];
                    y_hist_reg[k] <= y_hist_reg[k-1];
                end
                // feed back the saturated output
                x_hist_reg[0] <= x_reg;
                y_hist_reg[0] <= y_calc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            x_reg <= s_tdata[SAMPLE_WIDTH-1:0];
        end
        if (advance)
        begin
            y_reg    <= y_calc;
            clip_reg <= clip_calc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-SAMPLE_WIDTH){1'b0}}, y_reg};
    assign m_tuser  = clip_reg;

    // a computed sample always lands in the output register
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("output register not loaded after advance");

    // both stages full and stalled: input must back-pressure
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full");

    // feedback history holds the very sample that went out
    a_hist_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (y_hist_reg[0] == y_reg))
        else $error("output history differs from delivered sample");

    // a clipped result sits at one of the rails
    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && clip_reg) |->
            ((y_reg == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}) ||
             (y_reg == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}})))
        else $error("clipped flag set on an unsaturated sample");

endmodule

`default_nettype wire

>>> rtl/core/iirbq_regs.sv
// Coefficient register file behind the APB-style configuration port.
`default_nettype none

module iirbq_regs
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [iirbq_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [iirbq_pkg::DATA_WIDTH-1:0] pwdata,
    output logic      [iirbq_pkg::DATA_WIDTH-1:0] prdata,
    output logic                                  pready,
    output iirbq_pkg::coef_set_t                  coef
);
    import iirbq_pkg::*;

    reg_idx_t  reg_idx;
    logic      wr_en;
    coef_set_t coef_reg;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign coef    = coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= COEF_B0_RESET;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end
        else if (wr_en)
        begin
            // drop writes to addresses past the last register
            unique case (reg_idx)
                REG_B0:  coef_reg.b0 <= pwdata[COEF_WIDTH-1:0];
                REG_B1:  coef_reg.b1 <= pwdata[COEF_WIDTH-1:0];
                REG_B2:  coef_reg.b2 <= pwdata[COEF_WIDTH-1:0];
                REG_A1:  coef_reg.a1 <= pwdata[COEF_WIDTH-1:0];
                REG_A2:  coef_reg.a2 <= pwdata[COEF_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_B0:  prdata = {{(DATA_WIDTH-COEF_WIDTH){1'b0}}, coef_reg.b0};
            REG_B1:  prdata = {{(DATA_WIDTH-COEF_WIDTH){1'b0}}, coef_reg.b1};
            REG_B2:  prdata = {{(DATA_WIDTH-COEF_WIDTH){1'b0}}, coef_reg.b2};
            REG_A1:  prdata = {{(DATA_WIDTH-COEF_WIDTH){1'b0}}, coef_reg.a1};
            REG_A2:  prdata = {{(DATA_WIDTH-COEF_WIDTH){1'b0}}, coef_reg.a2};
            default: prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/iirbq_mac.sv
// Multiply-accumulate, rounding and saturation for one filter output.
`default_nettype none

module iirbq_mac
#(
    parameter int SAMPLE_WIDTH   = iirbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = iirbq_pkg::COEF_FRAC_BITS_DEF,
    parameter int HIST_DEPTH     = 2
)
(
    input  wire logic signed [SAMPLE_WIDTH-1:0] x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] x_hist [HIST_DEPTH],
    input  wire logic signed [SAMPLE_WIDTH-1:0] y_hist [HIST_DEPTH],
    input  wire iirbq_pkg::coef_set_t           coef,
    output logic signed      [SAMPLE_WIDTH-1:0] y,
    output logic                                clip
);
    import iirbq_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    // three guard bits cover the sum of five products plus the rounding term
    localparam int ACC_W  = (PROD_W + 3 > COEF_FRAC_BITS + 2) ?
                            PROD_W + 3 : COEF_FRAC_BITS + 2;

    localparam logic signed [ACC_W-1:0] RND =
        {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [COEF_WIDTH-1:0] cb [HIST_DEPTH];
    logic signed [COEF_WIDTH-1:0] ca [HIST_DEPTH];
    logic signed [PROD_W-1:0]     prod_0;
    logic signed [PROD_W-1:0]     prod_ff [HIST_DEPTH];
    logic signed [PROD_W-1:0]     prod_fb [HIST_DEPTH];
    logic signed [ACC_W-1:0]      acc;
    logic signed [ACC_W-1:0]      acc_rnd;
    logic signed [ACC_W-1:0]      acc_sh;

    assign prod_0 = coef.b0 * x;

    for (genvar k = 0; k < HIST_DEPTH; k++)
    begin : g_tap
        if (k == 0)
        begin : g_first
            assign cb[k] = coef.b1;
            assign ca[k] = coef.a1;
        end
        else
        begin : g_second
            assign cb[k] = coef.b2;
            assign ca[k] = coef.a2;
        end
        assign prod_ff[k] = cb[k] * x_hist[k];
        assign prod_fb[k] = ca[k] * y_hist[k];
    end

    always_comb
    begin
        acc = ACC_W'(prod_0);
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            acc = acc + ACC_W'(prod_ff[k]) - ACC_W'(prod_fb[k]);
        end
        // round half up, then floor shift
        acc_rnd = acc + RND;
        acc_sh  = acc_rnd >>> COEF_FRAC_BITS;
        if (acc_sh > SAT_HI)
        begin
            y    = SAT_HI[SAMPLE_WIDTH-1:0];
            clip = 1'b1;
        end
        else if (acc_sh < SAT_LO)
        begin
            y    = SAT_LO[SAMPLE_WIDTH-1:0];
            clip = 1'b1;
        end
        else
        begin
            y    = acc_sh[SAMPLE_WIDTH-1:0];
            clip = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the direct form 1 biquad core: stream traffic, APB coefficient loads.
`timescale 1ns / 1ps

module testbench;

    import iirbq_pkg::*;

    localparam int SW   = SAMPLE_WIDTH_DEF;
    localparam int FRAC = COEF_FRAC_BITS_DEF;
    localparam int TW   = ((SW + 7) / 8) * 8;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_B0_RESET;

    typedef struct {
        logic [SW-1:0] sample_out;
        logic          clipped;
    } filtered_beat_t;

    // Clock, reset and every block input start from known values.
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TW-1:0]         s_tdata  = '0;   // bits up from 0: sample_in
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TW-1:0]         m_tdata;         // bits up from 0: sample_out
    logic                  m_tuser;         // bit 0: clipped
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr    = '0;
    logic [DATA_WIDTH-1:0] pwdata   = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    // Shadow of the coefficient registers and the filter history.
    logic signed [COEF_WIDTH-1:0] coef [NUM_REGS];
    logic signed [SW-1:0]         x_hist [2];
    logic signed [SW-1:0]         y_hist [2];

    logic signed [SW-1:0] pending_samples [$];
    filtered_beat_t       expected_outputs [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int error_count     = 0;
    int samples_checked = 0;
    int coef_sets       = 0;

    iir_biquad_direct_form_one_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run one sample through the shadow filter: exact wide sum, round half up,
    // clamp, then shift the clamped output into the feedback history.
    function automatic void filter_sample(logic signed [SW-1:0] x);
        longint         acc;
        longint         y;
        filtered_beat_t beat;
        acc = longint'(coef[REG_B0]) * longint'(x)
            + longint'(coef[REG_B1]) * longint'(x_hist[0])
            + longint'(coef[REG_B2]) * longint'(x_hist[1])
            - longint'(coef[REG_A1]) * longint'(y_hist[0])
            - longint'(coef[REG_A2]) * longint'(y_hist[1]);
        acc = acc + (longint'(1) <<< (FRAC - 1));
        y = acc >>> FRAC;
        beat.clipped = 1'b0;
        if (y > longint'(SAMPLE_MAX))
        begin
            y = longint'(SAMPLE_MAX);
            beat.clipped = 1'b1;
        end
        else if (y < longint'(SAMPLE_MIN))
        begin
            y = longint'(SAMPLE_MIN);
            beat.clipped = 1'b1;
        end
        beat.sample_out = y[SW-1:0];
        x_hist[1] = x_hist[0];
        x_hist[0] = x;
        y_hist[1] = y_hist[0];
        y_hist[0] = y[SW-1:0];
        expected_outputs.push_back(beat);
    endfunction

    // Driver: predict on every accepted beat, then offer the next sample or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                filter_sample(s_tdata[SW-1:0]);
            if (!s_tvalid || s_tready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= TW'(pending_samples.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction, then pick
    // the ready level for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        filtered_beat_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result beat with none expected: sample_out %h clipped %b",
                             $time, m_tdata[SW-1:0], m_tuser);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    samples_checked++;
                    if (m_tdata[SW-1:0] !== want.sample_out)
                    begin
                        error_count++;
                        $display("%0t: sample_out mismatch: expected %h actual %h",
                                 $time, want.sample_out, m_tdata[SW-1:0]);
                    end
                    if (m_tuser !== want.clipped)
                    begin
                        error_count++;
                        $display("%0t: clipped mismatch: expected %b actual %b",
                                 $time, want.clipped, m_tuser);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Setup and access phase; the register takes the data at the access edge.
    task automatic apb_write(logic [ADDR_WIDTH-1:0] addr, logic [DATA_WIDTH-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Addresses past the last register are dropped; only 18 bits are kept.
        if (addr[ADDR_WIDTH-1:2] < NUM_REGS)
            coef[addr[ADDR_WIDTH-1:2]] = data[COEF_WIDTH-1:0];
    endtask

    task automatic apb_check(reg_idx_t idx);
        logic [DATA_WIDTH-1:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[COEF_WIDTH-1:0] !== coef[idx])
        begin
            error_count++;
            $display("%0t: readback of %s: expected %h actual %h",
                     $time, idx.name(), coef[idx], got[COEF_WIDTH-1:0]);
        end
    endtask

    // Load a full coefficient set. Junk goes into the unused upper bits, a stray
    // write lands past the register map, and every register is read back.
    task automatic set_coefs(logic signed [COEF_WIDTH-1:0] b0, logic signed [COEF_WIDTH-1:0] b1,
                             logic signed [COEF_WIDTH-1:0] b2, logic signed [COEF_WIDTH-1:0] a1,
                             logic signed [COEF_WIDTH-1:0] a2);
        logic signed [COEF_WIDTH-1:0] vals [NUM_REGS];
        logic [DATA_WIDTH-COEF_WIDTH-1:0] junk;
        reg_idx_t idx;
        vals = '{b0, b1, b2, a1, a2};
        for (int i = 0; i < NUM_REGS; i++)
        begin
            idx  = reg_idx_t'(i);
            junk = ($urandom_range(1) != 0) ? (DATA_WIDTH-COEF_WIDTH)'($urandom) : '0;
            apb_write({idx, 2'b00}, {junk, vals[i]});
        end
        apb_write(ADDR_WIDTH'($urandom_range(NUM_REGS, 7) * 4), $urandom);
        for (int i = 0; i < NUM_REGS; i++)
            apb_check(reg_idx_t'(i));
        coef_sets++;
    endtask

    // Hold until every queued sample went in and every result came back.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_tvalid || expected_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic play(logic signed [SW-1:0] samples [$]);
        foreach (samples[i])
            pending_samples.push_back(samples[i]);
        wait_drained();
    endtask

    function automatic logic signed [COEF_WIDTH-1:0] rand_coef(int span);
        return COEF_WIDTH'($urandom_range(2 * span) - span);
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return ($urandom_range(1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
        else if (pick <= 3)
            return SW'($urandom_range(600) - 300);
        else
            return SW'($urandom);
    endfunction

    initial
    begin
        logic signed [SW-1:0] burst [$];
        int idle_send [4] = '{0, 84, 0, 37};
        int idle_recv [4] = '{0, 0, 84, 37};

        coef = '{COEF_B0_RESET, '0, '0, '0, '0};
        x_hist = '{'0, '0};
        y_hist = '{'0, '0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset coefficients: plain pass-through at the sample extremes.
        for (int i = 0; i < NUM_REGS; i++)
            apb_check(reg_idx_t'(i));
        play('{0, 1, -1, SAMPLE_MAX, SAMPLE_MIN});

        // Half gain: odd inputs land on exact ties, which round up.
        set_coefs(COEF_ONE / 2, 0, 0, 0, 0);
        play('{1, -1, 3, -3});

        // Largest gain clips both ways.
        set_coefs(COEF_MAX, 0, 0, 0, 0);
        play('{SAMPLE_MAX, SAMPLE_MIN});

        // Every coefficient at its most negative value, feedback included.
        set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        play('{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 0});

        // Pure delay taps.
        set_coefs(0, COEF_ONE, COEF_ONE, 0, 0);
        play('{100, 200, 300});

        // Integrator: the fed-back output runs into saturation.
        set_coefs(COEF_ONE, 0, 0, -COEF_ONE, 0);
        play('{30000, 30000, 30000});

        // Feedback from two back only, largest positive.
        set_coefs(COEF_ONE, 0, 0, 0, COEF_MAX);
        play('{SAMPLE_MAX, 1});

        // Random part: four pacing modes, several coefficient sets in each.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = idle_send[phase];
            recv_stall_pct = idle_recv[phase];
            for (int seg = 0; seg < 4; seg++)
            begin
                case ((phase * 4 + seg) % 5)
                    0: set_coefs(rand_coef(131072), rand_coef(131072), rand_coef(131072),
                                 rand_coef(131072), rand_coef(131072));
                    1: set_coefs(rand_coef(16384), rand_coef(16384), rand_coef(16384),
                                 rand_coef(24576), COEF_WIDTH'($urandom_range(12000)));
                    2: set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
                    3: set_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
                    default: set_coefs(rand_coef(40000), rand_coef(40000), rand_coef(40000),
                                       rand_coef(40000), rand_coef(16000));
                endcase
                burst.delete();
                repeat (80) burst.push_back(rand_sample());
                play(burst);
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        $display("Checked %0d filtered samples across %0d coefficient sets,",
                 samples_checked, coef_sets);
        $display("with free-running, sender-idle, receiver-stall and mixed pacing.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("Timeout: traffic did not drain");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> iir_biquad_direct_form_one_core.f
rtl/core/iirbq_pkg.sv
rtl/core/iirbq_regs.sv
rtl/core/iirbq_mac.sv
rtl/core/iir_biquad_direct_form_one_core.sv
bench/testbench.sv
